// File: hdl/bis_pkg.sv
// ----------------------------------------------------------------------------
// Byte insertion sorter package
// Shared types, constants and control structs for the byte insertion sorter.
// ----------------------------------------------------------------------------
package bis_pkg;

  // Width of one byte of the string.
  localparam int unsigned ByteW = 8;

  // Default number of bytes the sorted store holds.
  localparam int unsigned DefaultDepth = 64;

  // Input word: one byte of the string and its end marker.
  typedef struct packed {
    logic [ByteW-1:0] ch;
    logic             last;
  } in_word_t;

  // Output word: one sorted byte and the end-of-string marker.
  typedef struct packed {
    logic [ByteW-1:0] sorted_ch;
    logic             final_res;
  } out_word_t;

  // Controller states.
  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic insert;
    logic pop;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_one;
  } status_t;

endpackage

// File: hdl/byte_insertion_sorter.sv
// ----------------------------------------------------------------------------
// Byte insertion sorter
// Collects a string byte by byte in a sorted store and emits it in ascending
// unsigned order once the byte marked last arrives.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake                  | Word
//   --------+----------------------------+-------------------------------
//   in      | in_valid_i / in_ready_o    | in_data_i   (ch, last)
//   out     | out_valid_o / out_ready_i  | out_data_o  (sorted_ch, final_res)
//
// Each input word is inserted as it is accepted, by the parallel
// compare-and-shift row of cells. After the word marked last, the block
// drains one word per cycle while out_ready_i is high, and takes no input
// until the last sorted word is taken.
// Bytes arriving with the store full are dropped. Reset clears the fill count
// and returns the block to accepting input; no clearing pass is needed.
//
module byte_insertion_sorter #(
  parameter int unsigned DEPTH = bis_pkg::DefaultDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bis_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bis_pkg::out_word_t out_data_o
);

  bis_pkg::cmd_t    cmd;
  bis_pkg::status_t status;

  // Sequencer.
  bis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Sorted store.
  bis_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .ch_i       (in_data_i.ch),
    .status_o   (status),
    .out_word_o (out_data_o)
  );

endmodule

// File: hdl/bis_ctrl.sv
// ----------------------------------------------------------------------------
// Byte insertion sorter controller
// Two-state sequencer: fill the sorted store, then drain it in order.
// ----------------------------------------------------------------------------
module bis_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  bis_pkg::status_t status_i,
  output bis_pkg::cmd_t    cmd_o
);

  bis_pkg::state_e state_q, state_d;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bis_pkg::ST_FILL: begin
        if (in_valid_i && in_last_i) begin
          state_d = bis_pkg::ST_DRAIN;
        end
      end
      bis_pkg::ST_DRAIN: begin
        if (out_ready_i && status_i.last_one) begin
          state_d = bis_pkg::ST_FILL;
        end
      end
      default: state_d = bis_pkg::ST_FILL;
    endcase
  end

  // Output logic: handshakes and datapath commands.
  always_comb begin
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    cmd_o.insert = 1'b0;
    cmd_o.pop    = 1'b0;
    unique case (state_q)
      bis_pkg::ST_FILL: begin
        in_ready_o   = 1'b1;
        cmd_o.insert = in_valid_i;
      end
      bis_pkg::ST_DRAIN: begin
        out_valid_o = 1'b1;
        cmd_o.pop   = out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bis_pkg::ST_FILL;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/bis_datapath.sv
// ----------------------------------------------------------------------------
// Byte insertion sorter datapath
// Row of byte cells kept in ascending order with a parallel compare-and-shift
// insert, drained by shifting toward cell zero.
// ----------------------------------------------------------------------------
module bis_datapath #(
  parameter int unsigned DEPTH = bis_pkg::DefaultDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bis_pkg::cmd_t              cmd_i,
  input  logic [bis_pkg::ByteW-1:0]  ch_i,
  output bis_pkg::status_t           status_o,
  output bis_pkg::out_word_t         out_word_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [bis_pkg::ByteW-1:0] store_q [DEPTH];
  logic [bis_pkg::ByteW-1:0] store_d [DEPTH];
  logic [DEPTH-1:0]          gt;
  logic [CntW-1:0]           count_q, count_d;
  logic                      full;

  assign full = (count_q == CntW'(DEPTH));

  // Each cell compares its byte against the new one; the row is sorted,
  // so the set of cells holding a larger byte is contiguous at the top.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i] = (CntW'(i) < count_q) && (store_q[i] > ch_i);
    end
  end

  // Per-cell update: take the lower neighbor, the new byte, or the upper
  // neighbor while draining.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      prev_gt;
    logic [bis_pkg::ByteW-1:0] prev_val;
    logic [bis_pkg::ByteW-1:0] next_val;
    logic                      at_end;

    if (i == 0) begin : g_first
      assign prev_gt  = 1'b0;
      assign prev_val = ch_i;
    end else begin : g_rest
      assign prev_gt  = gt[i-1];
      assign prev_val = store_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_top
      assign next_val = store_q[i];
    end else begin : g_below
      assign next_val = store_q[i+1];
    end

    assign at_end = (CntW'(i) == count_q);

    always_comb begin
      store_d[i] = store_q[i];
      if (cmd_i.insert && !full) begin
        if (prev_gt) begin
          store_d[i] = prev_val;
        end else if (gt[i] || at_end) begin
          store_d[i] = ch_i;
        end
      end else if (cmd_i.pop) begin
        store_d[i] = next_val;
      end
    end

    // Byte cells carry no reset; only filled cells are ever read.
    always_ff @(posedge clk_i) begin
      store_q[i] <= store_d[i];
    end
  end

  // Fill count: grows on an insert that fits, shrinks on each drained word.
  always_comb begin
    count_d = count_q;
    if (cmd_i.insert && !full) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // The smallest remaining byte always sits in cell zero.
  assign status_o.last_one     = (count_q == CntW'(1));
  assign out_word_o.sorted_ch  = store_q[0];
  assign out_word_o.final_res  = status_o.last_one;

endmodule
